FILE: sv/srx_pkg.sv
// ----------------------------------------------------------------------------
// srx_pkg: shared constants for the scrypt ROMix core
// Block geometry, scratchpad sizing and the word-0 tweak constants.
// ----------------------------------------------------------------------------
package srx_pkg;

    localparam int unsigned COST        = 1024;
    localparam int unsigned BLOCK_WORDS = 32;
    localparam int unsigned HALF_WORDS  = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned IDX_W       = (COST > 1) ? $clog2(COST) : 1;
    localparam int unsigned WSEL_W      = 5;
    localparam int unsigned HSEL_W      = 4;
    localparam int unsigned PAD_DEPTH   = COST * BLOCK_WORDS;
    localparam int unsigned PAD_AW      = $clog2(PAD_DEPTH);
    localparam int unsigned CNT_W       = IDX_W + 1;
    localparam int unsigned DR_COUNT    = 4;

    localparam logic [31:0] TWEAK_HI_MASK = 32'hffff8000;
    localparam logic [31:0] TWEAK_LO_MASK = 32'h00007fff;
    localparam logic [31:0] TWEAK_ADD     = 32'h000000e0;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t bswap(input word_t v);
        bswap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic word_t tweak_word(input word_t w);
        word_t v;
        v = bswap(w);
        v = (v & TWEAK_HI_MASK) | ((v + TWEAK_ADD) & TWEAK_LO_MASK);
        tweak_word = bswap(v);
    endfunction

endpackage

FILE: sv/scrypt_romix_salsa8_tweak_core.sv
// ----------------------------------------------------------------------------
// scrypt_romix_salsa8_tweak_core: scrypt ROMix (r=1, Salsa20/8) with tweak
// Gathers a 32-word block, runs ROMix against a scratchpad RAM, tweaks
// word 0 and streams the 32 result words.
// ----------------------------------------------------------------------------
// Fill step: scratchpad writes of the 32 block words, then two Salsa20/8 halves.
// Mix step: registered reads of scratchpad entry j, XORed in, then the same two halves.
// All 32 words are taken one a cycle while loading; the next load follows result word 31.
// Reset clears control state only; scratchpad and work block are undefined.
// ----------------------------------------------------------------------------
module scrypt_romix_salsa8_tweak_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic        out_last
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_COPY = 3'd1;
    localparam logic [2:0] S_MIXA = 3'd2;
    localparam logic [2:0] S_MIXB = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // state, pass 0 = fill, pass 1 = mix
    logic [2:0]                 st_reg;
    logic                       pass_reg;
    logic [srx_pkg::CNT_W-1:0]  it_reg;
    logic [5:0]                 w_reg;       // word step within copy 0..32, read 0..33
    logic [4:0]                 load_reg;
    logic                       ostart_reg;

    srx_pkg::word_t blk_reg [srx_pkg::BLOCK_WORDS];
    srx_pkg::word_t ow_reg;
    logic           ol_reg;
    logic           ov_reg;

    // scratchpad port
    logic                       pad_we;
    logic [srx_pkg::PAD_AW-1:0] pad_addr;
    srx_pkg::word_t             pad_rdata;
    logic [srx_pkg::IDX_W-1:0]  jidx;
    logic [srx_pkg::IDX_W-1:0]  j_reg;

    // salsa
    logic           sa_start;
    logic           sa_done;
    srx_pkg::word_t sa_din  [srx_pkg::HALF_WORDS];
    srx_pkg::word_t sa_dout [srx_pkg::HALF_WORDS];

    srx_ram #(
        .WIDTH (srx_pkg::WORD_W),
        .DEPTH (srx_pkg::PAD_DEPTH)
    ) u_pad (
        .clk   (clk),
        .we    (pad_we),
        .addr  (pad_addr),
        .wdata (blk_reg[w_reg[4:0]]),
        .rdata (pad_rdata)
    );

    srx_salsa u_salsa (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sa_start),
        .din   (sa_din),
        .done  (sa_done),
        .dout  (sa_dout)
    );

    // entry index from the new word 16, latched into j_reg for the next read step
    assign jidx = srx_pkg::IDX_W'(sa_dout[0] & 32'(srx_pkg::COST - 1));

    always_comb
    begin
        pad_we   = (st_reg == S_COPY) && !w_reg[5];
        pad_addr = (st_reg == S_COPY)
                 ? {it_reg[srx_pkg::IDX_W-1:0], w_reg[4:0]}
                 : {j_reg, w_reg[4:0]};
        sa_start = 1'b0;
        if (st_reg == S_COPY && w_reg[5])
        begin
            sa_start = 1'b1;
        end
        if (st_reg == S_READ && w_reg == 6'd33)
        begin
            sa_start = 1'b1;
        end
        if (st_reg == S_MIXA && sa_done)
        begin
            sa_start = 1'b1;
        end
        for (int i = 0; i < srx_pkg::HALF_WORDS; i++)
        begin
            if (st_reg == S_MIXA && sa_done)
            begin
                sa_din[i] = blk_reg[i + srx_pkg::HALF_WORDS] ^ sa_dout[i];
            end
            else
            begin
                sa_din[i] = blk_reg[i] ^ blk_reg[i + srx_pkg::HALF_WORDS];
            end
        end
    end

    assign in_ready  = (st_reg == S_LOAD);
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;
    assign out_last  = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_LOAD;
            pass_reg   <= 1'b0;
            it_reg     <= '0;
            w_reg      <= '0;
            load_reg   <= '0;
            ov_reg     <= 1'b0;
            ostart_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready && st_reg != S_OUT)
            begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        load_reg <= load_reg + 5'd1;
                        if (load_reg == 5'd31)
                        begin
                            st_reg   <= S_COPY;
                            pass_reg <= 1'b0;
                            it_reg   <= '0;
                            w_reg    <= '0;
                        end
                    end
                end
                S_COPY:
                begin
                    w_reg <= w_reg + 6'd1;
                    if (w_reg[5])
                    begin
                        st_reg <= S_MIXA;
                    end
                end
                S_READ:
                begin
                    // read data returns in the cycle after its address
                    w_reg <= w_reg + 6'd1;
                    if (w_reg == 6'd33)
                    begin
                        st_reg <= S_MIXA;
                    end
                end
                S_MIXA:
                begin
                    if (sa_done)
                    begin
                        st_reg <= S_MIXB;
                    end
                end
                S_MIXB:
                begin
                    if (sa_done)
                    begin
                        w_reg <= '0;
                        if (it_reg == srx_pkg::CNT_W'(srx_pkg::COST - 1))
                        begin
                            it_reg <= '0;
                            if (pass_reg)
                            begin
                                st_reg     <= S_OUT;
                                ostart_reg <= 1'b1;
                            end
                            else
                            begin
                                pass_reg <= 1'b1;
                                st_reg   <= S_READ;
                            end
                        end
                        else
                        begin
                            it_reg <= it_reg + srx_pkg::CNT_W'(1);
                            st_reg <= pass_reg ? S_READ : S_COPY;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg     <= 1'b1;
                        ostart_reg <= 1'b0;
                        if (w_reg == 6'd31)
                        begin
                            st_reg <= S_LOAD;
                            w_reg  <= '0;
                        end
                        else
                        begin
                            w_reg <= w_reg + 6'd1;
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_LOAD && in_valid)
        begin
            blk_reg[load_reg] <= in_word;
        end
        if (st_reg == S_READ && w_reg != 6'd0 && w_reg != 6'd33)
        begin
            blk_reg[5'(w_reg - 6'd1)] <= blk_reg[5'(w_reg - 6'd1)] ^ pad_rdata;
        end
        if (st_reg == S_MIXB && sa_done)
        begin
            j_reg <= jidx;
        end
        if (sa_done)
        begin
            for (int i = 0; i < srx_pkg::HALF_WORDS; i++)
            begin
                if (st_reg == S_MIXA)
                begin
                    blk_reg[i] <= sa_dout[i];
                end
                else
                begin
                    blk_reg[i + srx_pkg::HALF_WORDS] <= sa_dout[i];
                end
            end
        end
        if (st_reg == S_OUT && (!ov_reg || out_ready))
        begin
            ow_reg <= ostart_reg ? srx_pkg::tweak_word(blk_reg[0])
                                 : blk_reg[w_reg[4:0]];
            ol_reg <= (w_reg == 6'd31);
        end
    end

endmodule

FILE: sv/srx_ram.sv
// ----------------------------------------------------------------------------
// srx_ram: generic single-port synchronous RAM
// One read per cycle and a write when we is high; read data registered.
// ----------------------------------------------------------------------------
module srx_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/srx_salsa.sv
// ----------------------------------------------------------------------------
// srx_salsa: Salsa20/8 core, one double round per cycle
// Loads 16 words, runs four double rounds, then adds the input back.
// ----------------------------------------------------------------------------
module srx_salsa (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  srx_pkg::word_t    din  [srx_pkg::HALF_WORDS],
    output logic              done,
    output srx_pkg::word_t    dout [srx_pkg::HALF_WORDS]
);

    srx_pkg::word_t x_reg [srx_pkg::HALF_WORDS];
    srx_pkg::word_t b_reg [srx_pkg::HALF_WORDS];
    srx_pkg::word_t dr    [srx_pkg::HALF_WORDS];
    logic [2:0] rnd_reg;
    logic       busy_reg;

    function automatic srx_pkg::word_t rotl(input srx_pkg::word_t v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    always_comb
    begin
        srx_pkg::word_t y [srx_pkg::HALF_WORDS];
        y = x_reg;
        // columns
        y[4]  ^= rotl(y[0]  + y[12], 7);  y[8]  ^= rotl(y[4]  + y[0],  9);
        y[12] ^= rotl(y[8]  + y[4], 13);  y[0]  ^= rotl(y[12] + y[8], 18);
        y[9]  ^= rotl(y[5]  + y[1],  7);  y[13] ^= rotl(y[9]  + y[5],  9);
        y[1]  ^= rotl(y[13] + y[9], 13);  y[5]  ^= rotl(y[1]  + y[13], 18);
        y[14] ^= rotl(y[10] + y[6],  7);  y[2]  ^= rotl(y[14] + y[10], 9);
        y[6]  ^= rotl(y[2]  + y[14], 13); y[10] ^= rotl(y[6]  + y[2],  18);
        y[3]  ^= rotl(y[15] + y[11], 7);  y[7]  ^= rotl(y[3]  + y[15], 9);
        y[11] ^= rotl(y[7]  + y[3], 13);  y[15] ^= rotl(y[11] + y[7],  18);
        // rows
        y[1]  ^= rotl(y[0]  + y[3],  7);  y[2]  ^= rotl(y[1]  + y[0],  9);
        y[3]  ^= rotl(y[2]  + y[1], 13);  y[0]  ^= rotl(y[3]  + y[2],  18);
        y[6]  ^= rotl(y[5]  + y[4],  7);  y[7]  ^= rotl(y[6]  + y[5],  9);
        y[4]  ^= rotl(y[7]  + y[6], 13);  y[5]  ^= rotl(y[4]  + y[7],  18);
        y[11] ^= rotl(y[10] + y[9],  7);  y[8]  ^= rotl(y[11] + y[10], 9);
        y[9]  ^= rotl(y[8]  + y[11], 13); y[10] ^= rotl(y[9]  + y[8],  18);
        y[12] ^= rotl(y[15] + y[14], 7);  y[13] ^= rotl(y[12] + y[15], 9);
        y[14] ^= rotl(y[13] + y[12], 13); y[15] ^= rotl(y[14] + y[13], 18);
        dr = y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            rnd_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rnd_reg <= rnd_reg + 3'd1;
            if (rnd_reg == 3'(srx_pkg::DR_COUNT - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= din;
            b_reg <= din;
        end
        else if (busy_reg)
        begin
            x_reg <= dr;
        end
    end

    assign done = busy_reg && (rnd_reg == 3'(srx_pkg::DR_COUNT - 1));

    always_comb
    begin
        for (int i = 0; i < srx_pkg::HALF_WORDS; i++)
        begin
            dout[i] = b_reg[i] + dr[i];
        end
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for scrypt_romix_salsa8_tweak_core
// Feeds 32-word blocks and predicts each result block with a behavioural
// ROMix (Salsa20/8, r=1) plus the word-0 tweak. Both sides idle and stall
// at random over several phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned IDLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] in_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_word;
    logic        out_last;

    scrypt_romix_salsa8_tweak_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .out_last  (out_last)
    );

    // predictor state
    logic [31:0] blk_words [srx_pkg::BLOCK_WORDS];
    logic [31:0] romix_pad [srx_pkg::COST][srx_pkg::BLOCK_WORDS];
    int unsigned words_gathered;
    logic [31:0] exp_word_q [$];
    logic        exp_last_q [$];

    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    // dst ^= src; dst += salsa20/8(dst) over one 16-word half
    function automatic void salsa_half(input int dst, input int src);
        logic [31:0] x [srx_pkg::HALF_WORDS];
        int r;
        int q;
        int a, b, c, d;
        int quads [8][4] = '{'{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6},
                             '{15, 3, 7, 11}, '{0, 1, 2, 3}, '{5, 6, 7, 4},
                             '{10, 11, 8, 9}, '{15, 12, 13, 14}};
        for (int i = 0; i < srx_pkg::HALF_WORDS; i++)
        begin
            blk_words[dst + i] = blk_words[dst + i] ^ blk_words[src + i];
            x[i] = blk_words[dst + i];
        end
        for (r = 0; r < 4; r++)
            for (q = 0; q < 8; q++)
            begin
                a = quads[q][0]; b = quads[q][1]; c = quads[q][2]; d = quads[q][3];
                x[b] = x[b] ^ rotl(x[a] + x[d], 7);
                x[c] = x[c] ^ rotl(x[b] + x[a], 9);
                x[d] = x[d] ^ rotl(x[c] + x[b], 13);
                x[a] = x[a] ^ rotl(x[d] + x[c], 18);
            end
        for (int i = 0; i < srx_pkg::HALF_WORDS; i++)
            blk_words[dst + i] = blk_words[dst + i] + x[i];
    endfunction

    function automatic void mix_block();
        salsa_half(0, srx_pkg::HALF_WORDS);
        salsa_half(srx_pkg::HALF_WORDS, 0);
    endfunction

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // runs the full ROMix on the gathered block and queues 32 result words
    function automatic void predict_block();
        logic [31:0] idx;
        logic [31:0] v;
        for (int i = 0; i < srx_pkg::COST; i++)
        begin
            for (int k = 0; k < srx_pkg::BLOCK_WORDS; k++)
                romix_pad[i][k] = blk_words[k];
            mix_block();
        end
        for (int i = 0; i < srx_pkg::COST; i++)
        begin
            idx = blk_words[srx_pkg::HALF_WORDS] & (srx_pkg::COST - 1);
            for (int k = 0; k < srx_pkg::BLOCK_WORDS; k++)
                blk_words[k] = blk_words[k] ^ romix_pad[idx][k];
            mix_block();
        end
        v = swap_bytes(blk_words[0]);
        v = (v & srx_pkg::TWEAK_HI_MASK)
          | ((v + srx_pkg::TWEAK_ADD) & srx_pkg::TWEAK_LO_MASK);
        blk_words[0] = swap_bytes(v);
        for (int k = 0; k < srx_pkg::BLOCK_WORDS; k++)
        begin
            exp_word_q.push_back(blk_words[k]);
            exp_last_q.push_back(k == srx_pkg::BLOCK_WORDS - 1);
        end
    endfunction

    task automatic send_word(input logic [31:0] w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        blk_words[words_gathered] = w;
        if (words_gathered == srx_pkg::BLOCK_WORDS - 1)
        begin
            words_gathered = 0;
            predict_block();
        end
        else
            words_gathered++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // receiver stall
    always @(negedge clk)
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_word_q.size() == 0)
            begin
                $display("%0t: unexpected result word %h last %b", $time, out_word, out_last);
                fail_count++;
            end
            else
            begin
                if (out_word !== exp_word_q[0])
                begin
                    $display("%0t: out_word expected %h actual %h",
                             $time, exp_word_q[0], out_word);
                    fail_count++;
                end
                if (out_last !== exp_last_q[0])
                begin
                    $display("%0t: out_last expected %b actual %b",
                             $time, exp_last_q[0], out_last);
                    fail_count++;
                end
                void'(exp_word_q.pop_front());
                void'(exp_last_q.pop_front());
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one block of extreme and patterned words
    task automatic test_extreme_block();
        logic [31:0] pat [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                                 32'h7fff_ffff, 32'haaaa_aaaa, 32'h5555_5555,
                                 32'h0000_0001, 32'hfffe_ffff};
        for (int k = 0; k < srx_pkg::BLOCK_WORDS; k++)
            send_word(pat[k % 8] ^ (k[4:0] << 8));
    endtask

    task automatic test_random_blocks(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int b = 0; b < n; b++)
            for (int k = 0; k < srx_pkg::BLOCK_WORDS; k++)
                send_word($urandom());
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        fail_count = 0;
        quiet_cycles = 0;
        words_gathered = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extreme_block();
        test_random_blocks(1, 0, 0);
        test_random_blocks(2, 70, 0);
        test_random_blocks(2, 0, 70);
        test_random_blocks(2, 21, 21);
        release_input();

        waited = 0;
        while (exp_word_q.size() != 0 && waited < IDLE_LIMIT * 2)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0 && exp_word_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
